FILE: design/sbmsh_pkg.sv
package sbmsh_pkg;

    localparam int CHAR_W       = 8;
    localparam int WORD_W       = 32;
    localparam int BYTE_W       = 8;
    localparam int NUM_BYTES    = WORD_W / BYTE_W;
    localparam int POS_W        = 2;
    localparam int FINAL_ROUNDS = 8;
    localparam int ROUND_W      = $clog2(FINAL_ROUNDS);
    localparam int QUEUE_DEPTH  = 2;

    // One queued character, tagged by the front end.
    typedef struct packed {
        logic [CHAR_W-1:0] char_code;
        logic              terminator;
    } item_t;

    // Head of the queue as seen by the back end.
    typedef struct packed {
        logic  valid;
        item_t item;
    } head_t;

    typedef enum logic [0:0] {
        ST_CHAR,
        ST_FINAL
    } state_t;

endpackage

FILE: design/sbmsh_front.sv
module sbmsh_front #(
    parameter int QueueDepth = sbmsh_pkg::QUEUE_DEPTH
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [sbmsh_pkg::CHAR_W-1:0]  s_tdata,
    output sbmsh_pkg::head_t              head,
    input  logic                          pop
);

    localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
    localparam int CntW = $clog2(QueueDepth + 1);

    sbmsh_pkg::item_t  entry_reg [QueueDepth];
    logic [PtrW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0]   count_reg, count_next;
    logic              push;
    logic              do_pop;
    sbmsh_pkg::item_t  new_item;

    // Tag terminators on the way in
    always_comb begin
        new_item.char_code  = s_tdata;
        new_item.terminator = (s_tdata == '0);
    end

    assign s_tready = (count_reg != CntW'(QueueDepth));
    assign push     = s_tvalid && s_tready;
    assign do_pop   = pop && (count_reg != '0);

    assign head.valid = (count_reg != '0);
    assign head.item  = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (!push && do_pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= new_item;
        end
    end

endmodule

FILE: design/sbmsh_back.sv
module sbmsh_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [sbmsh_pkg::WORD_W-1:0]  cfg_wdata,
    input  sbmsh_pkg::head_t              head,
    output logic                          pop,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [sbmsh_pkg::WORD_W-1:0]  m_tdata
);

    localparam int BW = sbmsh_pkg::BYTE_W;
    localparam int PW = sbmsh_pkg::POS_W;
    localparam int RW = sbmsh_pkg::ROUND_W;

    sbmsh_pkg::state_t                 state_reg, state_next;
    logic [sbmsh_pkg::WORD_W-1:0]      salt_reg;
    logic [sbmsh_pkg::WORD_W-1:0]      word_reg, word_next;
    logic [PW-1:0]                     pos_reg, pos_next;
    logic [RW-1:0]                     round_reg, round_next;
    logic                              m_tvalid_reg, m_tvalid_next;
    logic [sbmsh_pkg::WORD_W-1:0]      m_tdata_reg;

    logic                              out_free;
    logic                              last_round;
    logic                              mix_en;
    logic                              char_mix;
    logic                              emit;

    logic [sbmsh_pkg::NUM_BYTES-1:0][BW-1:0] bytes;
    logic [sbmsh_pkg::NUM_BYTES-1:0][BW-1:0] bytes_mixed;
    logic [PW-1:0]                     t_idx, a_idx, b_idx, c_idx;
    logic [BW-1:0]                     add_val;
    logic [2*BW-1:0]                   prod;
    logic [BW-1:0]                     new_byte;

    assign out_free   = !m_tvalid_reg || m_tready;
    assign last_round = (round_reg == RW'(sbmsh_pkg::FINAL_ROUNDS - 1));

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            sbmsh_pkg::ST_CHAR: begin
                if (head.valid && head.item.terminator) begin
                    state_next = sbmsh_pkg::ST_FINAL;
                end
            end
            sbmsh_pkg::ST_FINAL: begin
                if (last_round && out_free) begin
                    state_next = sbmsh_pkg::ST_CHAR;
                end
            end
            default: state_next = sbmsh_pkg::ST_CHAR;
        endcase
    end

    // FSM outputs
    always_comb begin
        pop      = 1'b0;
        char_mix = 1'b0;
        mix_en   = 1'b0;
        emit     = 1'b0;
        case (state_reg)
            sbmsh_pkg::ST_CHAR: begin
                pop      = head.valid;
                char_mix = head.valid && !head.item.terminator;
                mix_en   = char_mix;
            end
            sbmsh_pkg::ST_FINAL: begin
                // hold the last round until the output register frees up
                mix_en = !last_round || out_free;
                emit   = last_round && out_free;
            end
            default: begin
                pop = 1'b0;
            end
        endcase
    end

    // Shared byte mixer: target += add + a*b + c (mod 256)
    always_comb begin
        bytes = word_reg;
        if (char_mix) begin
            t_idx   = pos_reg;
            a_idx   = pos_reg + PW'(3);
            b_idx   = pos_reg + PW'(2);
            c_idx   = pos_reg + PW'(1);
            add_val = head.item.char_code;
        end else begin
            t_idx   = round_reg[PW-1:0] + PW'(3);
            a_idx   = round_reg[PW-1:0];
            b_idx   = round_reg[PW-1:0] + PW'(1);
            c_idx   = round_reg[PW-1:0] + PW'(2);
            add_val = '0;
        end
        prod     = bytes[a_idx] * bytes[b_idx];
        new_byte = bytes[t_idx] + add_val + prod[BW-1:0] + bytes[c_idx];
        bytes_mixed        = bytes;
        bytes_mixed[t_idx] = new_byte;
    end

    always_comb begin
        word_next  = word_reg;
        pos_next   = pos_reg;
        round_next = round_reg;
        if (emit) begin
            word_next = salt_reg;
            pos_next  = '0;
        end else if (mix_en) begin
            word_next = bytes_mixed;
        end
        if (char_mix) begin
            pos_next = pos_reg + 1'b1;
        end
        if (pop && head.item.terminator) begin
            round_next = '0;
        end else if ((state_reg == sbmsh_pkg::ST_FINAL) && mix_en) begin
            round_next = round_reg + 1'b1;
        end
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (emit) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= sbmsh_pkg::ST_CHAR;
            salt_reg     <= '0;
            word_reg     <= '0;
            pos_reg      <= '0;
            round_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            word_reg     <= word_next;
            pos_reg      <= pos_next;
            round_reg    <= round_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_we) begin
                salt_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            m_tdata_reg <= bytes_mixed;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

FILE: design/salted_byte_mix_string_hash_unit.sv
// Throughput: one nonzero character per cycle, unless the queue is empty or the back end is
//   busy with a terminator (dequeue, then eight final rounds on the shared 8x8 byte mixer).
// Result path: a terminator is dequeued, then eight rounds run, the last loading the output
//   register for the hash on m_tdata; a stalled output holds the last round.
// Reset (aresetn low, synchronous): empty queue, salt and mixing word zero, position zero,
//   no result pending.
module salted_byte_mix_string_hash_unit #(
    parameter int QueueDepth = sbmsh_pkg::QUEUE_DEPTH
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // salt register write
    input  logic                          cfg_we,
    input  logic [sbmsh_pkg::WORD_W-1:0]  cfg_wdata,
    // character stream
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [sbmsh_pkg::CHAR_W-1:0]  s_tdata,    // [7:0] char_code
    // hash results
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [sbmsh_pkg::WORD_W-1:0]  m_tdata     // [31:0] hash_value
);

    sbmsh_pkg::head_t head;
    logic             pop;

    // Front end: accept each transfer, flag terminators, hold them in a short queue
    sbmsh_front #(
        .QueueDepth (QueueDepth)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .head     (head),
        .pop      (pop)
    );

    // Back end: mix characters into the word, run the final rounds on a terminator,
    // then present the hash and reload the salt
    sbmsh_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .head      (head),
        .pop       (pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

FILE: bench/tb_top.sv
module tb_top;

    localparam int CLK_HALF      = 4;
    localparam int RESET_CYCLES  = 2;
    // Terminator to hash takes a dequeue plus the final rounds; allow for queued characters as well.
    localparam int DRAIN_CYCLES  = 30;
    localparam int HOLD_CYCLES   = 400;
    localparam int CYCLE_LIMIT   = 500000;
    localparam int PHASES        = 8;
    localparam int PHASE_ITEMS   = 115;
    localparam int PRESSURE_PHASE = 3;
    localparam int STEADY_PHASE  = 2;
    localparam int BURST_STRINGS = 80;

    localparam logic [sbmsh_pkg::CHAR_W-1:0] TERMINATOR = '0;

    // Tracks the expected hash of every string: a copy of the mixing state plus
    // the hashes still owed by the block, oldest first.
    class string_hash_tracker;
        logic [sbmsh_pkg::BYTE_W-1:0] mix_byte [sbmsh_pkg::NUM_BYTES];
        logic [sbmsh_pkg::POS_W-1:0]  position;
        logic [sbmsh_pkg::WORD_W-1:0] salt;
        logic [sbmsh_pkg::WORD_W-1:0] owed_hashes [$];
        int                           errors;

        function new();
            salt   = '0;
            errors = 0;
            reload_word();
        endfunction

        function void reload_word();
            for (int k = 0; k < sbmsh_pkg::NUM_BYTES; k++) begin
                mix_byte[k] = salt[sbmsh_pkg::BYTE_W*k +: sbmsh_pkg::BYTE_W];
            end
            position = '0;
        endfunction

        function void set_salt(logic [sbmsh_pkg::WORD_W-1:0] value);
            salt = value;
        endfunction

        function int owed();
            return owed_hashes.size();
        endfunction

        // Note one accepted character; a terminator closes the string and owes a hash.
        function void take_char(logic [sbmsh_pkg::CHAR_W-1:0] c);
            logic [sbmsh_pkg::POS_W-1:0]  a, b, d, t;
            logic [sbmsh_pkg::WORD_W-1:0] hash;
            if (c != TERMINATOR) begin
                a = position + 2'd3;
                b = position + 2'd2;
                d = position + 2'd1;
                mix_byte[position] = mix_byte[position] + c
                                     + mix_byte[a] * mix_byte[b] + mix_byte[d];
                position = position + 2'd1;
            end else begin
                for (int i = 0; i < sbmsh_pkg::FINAL_ROUNDS; i++) begin
                    a = sbmsh_pkg::POS_W'(i);
                    b = a + 2'd1;
                    d = a + 2'd2;
                    t = a + 2'd3;
                    mix_byte[t] = mix_byte[t] + mix_byte[a] * mix_byte[b] + mix_byte[d];
                end
                hash = {mix_byte[3], mix_byte[2], mix_byte[1], mix_byte[0]};
                owed_hashes = {owed_hashes, hash};
                reload_word();
            end
        endfunction

        task report(string msg);
            $display("[%0t] hash check: %s", $realtime, msg);
            errors++;
        endtask

        task match_hash(logic [sbmsh_pkg::WORD_W-1:0] got);
            logic [sbmsh_pkg::WORD_W-1:0] want;
            if (owed_hashes.size() == 0) begin
                report($sformatf("hash %08h with no string closed", got));
            end else begin
                want = owed_hashes.pop_front();
                if (got !== want) report($sformatf("hash %08h, expected %08h", got, want));
            end
        endtask

        task flush_owed();
            while (owed_hashes.size() > 0)
                report($sformatf("hash %08h never delivered", owed_hashes.pop_front()));
        endtask
    endclass

    // Drive every input to a known value from time zero.
    logic                          aclk      = 1'b0;
    logic                          aresetn   = 1'b0;
    logic                          cfg_we    = 1'b0;
    logic [sbmsh_pkg::WORD_W-1:0]  cfg_wdata = '0;
    logic                          s_tvalid  = 1'b0;
    logic                          s_tready;
    logic [sbmsh_pkg::CHAR_W-1:0]  s_tdata   = '0;   // [7:0] char_code
    logic                          m_tvalid;
    logic                          m_tready  = 1'b0;
    logic [sbmsh_pkg::WORD_W-1:0]  m_tdata;          // [31:0] hash_value

    string_hash_tracker tracker = new();

    // Shared between the stimulus and the receiver; they only shape the idling.
    bit idle_on       = 1'b1;
    int hold_requests = 0;

    int hold_served = 0;
    int hold_left   = 0;
    int stall_left  = 0;
    int cycle_count = 0;

    salted_byte_mix_string_hash_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #CLK_HALF aclk = ~aclk;

    // Gap length: mostly none, sometimes a few cycles, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!idle_on || r < 65) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // String length: mostly short, some empty, a few long enough to wrap often.
    function automatic int pick_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10) return 0;
        if (r < 85) return $urandom_range(1, 8);
        if (r < 97) return $urandom_range(9, 20);
        return $urandom_range(21, 60);
    endfunction

    // Offer one character and hold it until the transfer; then maybe idle a while.
    // Valid is lowered only when a gap follows, so it never toggles within one step.
    task automatic send_char(logic [sbmsh_pkg::CHAR_W-1:0] c);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        do @(posedge aclk); while (!s_tready);
        tracker.take_char(c);
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            s_tdata  <= sbmsh_pkg::CHAR_W'($urandom);
            repeat (gap) @(posedge aclk);
        end
    endtask

    // Random nonzero characters, closed by a terminator unless asked to leave it open.
    task automatic send_string(int len, bit close);
        for (int k = 0; k < len; k++) send_char(sbmsh_pkg::CHAR_W'($urandom_range(1, 255)));
        if (close) send_char(TERMINATOR);
    endtask

    // Drop valid, wait for every owed hash, then let queued characters drain through.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (tracker.owed() > 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_salt(logic [sbmsh_pkg::WORD_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        tracker.set_salt(value);
        cfg_we    <= 1'b0;
    endtask

    // Receiver: check each hash transfer, then pick next cycle's ready. A hold
    // request from the stimulus keeps ready low for a long, counted stretch.
    always @(posedge aclk) begin
        int r;
        if (aresetn && m_tvalid && m_tready) tracker.match_hash(m_tdata);
        if (hold_served != hold_requests) begin
            hold_served = hold_requests;
            hold_left   = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else if (!idle_on) begin
            m_tready <= 1'b1;
        end else begin
            r = $urandom_range(0, 99);
            if (r < 70) begin
                m_tready <= 1'b1;
            end else begin
                stall_left = (r < 95) ? $urandom_range(0, 2) : $urandom_range(8, 40);
                m_tready <= 1'b0;
            end
        end
    end

    // Watchdog: count cycles and give up at a generous limit.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        logic [sbmsh_pkg::CHAR_W-1:0] corner_chars [6];
        logic [sbmsh_pkg::WORD_W-1:0] salt_value;
        int                           target;
        int                           sent_items;

        corner_chars = '{8'hFF, 8'h01, 8'h80, 8'h7F, 8'h55, 8'hAA};
        sent_items   = 0;

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Empty string straight after reset: hash of the reset word alone.
        send_char(TERMINATOR);
        // Extreme and alternating character values in one string.
        foreach (corner_chars[k]) send_char(corner_chars[k]);
        send_char(TERMINATOR);

        // New salt: the word in use was loaded from the old salt, so the first empty
        // string still hashes that; the second picks up the all-ones salt.
        wait_drained();
        write_salt('1);
        send_char(TERMINATOR);
        send_char(TERMINATOR);

        // Salt written mid-string: the open string keeps its word.
        send_char(8'h61);
        send_char(8'h62);
        wait_drained();
        write_salt(32'h8000_0001);
        send_char(8'h63);
        send_char(TERMINATOR);

        // Long string: position wraps twice.
        for (int k = 0; k < 9; k++) send_char(sbmsh_pkg::CHAR_W'(8'hFF - k));
        send_char(TERMINATOR);

        // Random phases, each under its own salt; some end with a string left open.
        for (int phase = 0; phase < PHASES; phase++) begin
            wait_drained();
            case (phase)
                0:       salt_value = '0;
                1:       salt_value = '1;
                default: salt_value = $urandom;
            endcase
            write_salt(salt_value);
            idle_on = (phase != STEADY_PHASE) && (phase != PRESSURE_PHASE);

            if (phase == PRESSURE_PHASE) begin
                // Hold the receiver off and keep offering short strings back to back,
                // so the block fills up and stalls its input.
                hold_requests++;
                repeat (BURST_STRINGS) send_string($urandom_range(0, 3), 1'b1);
            end else begin
                target = sent_items + PHASE_ITEMS;
                while (sent_items < target) begin
                    int len;
                    len = pick_length();
                    send_string(len, 1'b1);
                    sent_items += len + 1;
                end
                if ($urandom_range(0, 1)) send_string($urandom_range(1, 5), 1'b0);
            end
        end

        wait_drained();
        tracker.flush_owed();
        if (tracker.errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

FILE: sim.f
design/sbmsh_pkg.sv
design/sbmsh_front.sv
design/sbmsh_back.sv
design/salted_byte_mix_string_hash_unit.sv
bench/tb_top.sv
